@@ rtl/maxrects_bssf_packer_macros.svh @@
// Assertion macros shared by the packer RTL.
// Depends on clk_i and rst_ni being visible where a macro is used.
`ifndef MAXRECTS_BSSF_PACKER_MACROS_SVH
`define MAXRECTS_BSSF_PACKER_MACROS_SVH

// Checked on every clock edge outside reset.
`define MBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, during reset too.
`define MBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/mbp_pkg.sv @@
// Shared codes for the MaxRects packer: result status and register indexes.
// No dependencies.
package mbp_pkg;

  localparam int unsigned CFG_IDX_W = 8;

  typedef enum logic [1:0] {
    STAT_PLACED = 2'd0,
    STAT_REJECT = 2'd1,
    STAT_NO_FIT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIN_WIDTH  = 8'd0,
    REG_BIN_HEIGHT = 8'd1
  } reg_idx_e;

endpackage

@@ rtl/mbp_ram.sv @@
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies; used for the free list and the scratch list.
module mbp_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ rtl/maxrects_bssf_packer.sv @@
// MaxRects best-short-side-fit packer: top level with sequencer.
// Depends on mbp_pkg, mbp_ram and maxrects_bssf_packer_macros.svh.
//
// Requests arrive as beats on the s_axis channel (width and height), and
// each gives exactly one result beat on m_axis (status, position, overflow).
// The cfg channel writes bin width or height; either write restarts the bin
// with one free rectangle covering it. It is taken only while idle.
// One request at a time: a search pass over the free list, a split pass
// that turns the free entries into pieces in the scratch list, a containment
// prune over pairs of scratch entries, and a copy back of the survivors to
// the free list; the prune over the scratch RAM dominates the work of a
// placement. Results sit in an output register, so a stalled receiver
// holds the finished beat while the next request is already accepted; a
// further result waits until that register is taken. Reset sets both sizes
// to the maximum and leaves the whole bin free; no clearing pass is needed.
module maxrects_bssf_packer #(
  parameter int unsigned MAX_FREE   = 64,
  parameter int unsigned WORK_DEPTH = 256,
  parameter int unsigned COORD_BITS = 13
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // rect_width, rect_height, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // status, pos_x, pos_y, free_overflow, zero pad
  output logic [((2*COORD_BITS+1+7)/8)*8-1:0]      m_axis_tdata,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [mbp_pkg::CFG_IDX_W-1:0]            cfg_index_i,
  input  logic [COORD_BITS-1:0]                    cfg_data_i
);

  import mbp_pkg::*;
  `include "maxrects_bssf_packer_macros.svh"

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned SW    = CB + 1;
  localparam int unsigned PW    = CB - 1;
  localparam int unsigned BW    = 4 * CB;
  localparam int unsigned FAW   = $clog2(MAX_FREE);
  localparam int unsigned WAW   = $clog2(WORK_DEPTH);
  localparam int unsigned FCW   = $clog2(MAX_FREE + 1);
  localparam int unsigned WCW   = $clog2(WORK_DEPTH + 1);
  localparam int unsigned IN_W  = ((2*CB+7)/8)*8;
  localparam int unsigned OUT_W = ((2*CB+1+7)/8)*8;
  localparam logic [CB-1:0] BIN_MAX = CB'(1) << (CB - 1);

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic [CB-1:0] w;
    logic [CB-1:0] h;
  } box_t;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_CHK     = 14'b00000000000010,
    ST_SR_RD   = 14'b00000000000100,
    ST_SR_EV   = 14'b00000000001000,
    ST_SP_RD   = 14'b00000000010000,
    ST_SP_GET  = 14'b00000000100000,
    ST_SP_PUSH = 14'b00000001000000,
    ST_PR_RDI  = 14'b00000010000000,
    ST_PR_GETI = 14'b00000100000000,
    ST_PR_RDJ  = 14'b00001000000000,
    ST_PR_CMP  = 14'b00010000000000,
    ST_CP_RD   = 14'b00100000000000,
    ST_CP_WR   = 14'b01000000000000,
    ST_FIN     = 14'b10000000000000
  } state_e;

  function automatic logic [SW-1:0] ext(input logic [CB-1:0] v);
    ext = {1'b0, v};
  endfunction

  function automatic logic box_holds(input box_t o, input box_t n);
    box_holds = (n.x >= o.x) && (n.y >= o.y) &&
                (ext(n.x) + ext(n.w) <= ext(o.x) + ext(o.w)) &&
                (ext(n.y) + ext(n.h) <= ext(o.y) + ext(o.h));
  endfunction

  state_e        state_q, state_d;
  logic [CB-1:0] bw_q, bw_d, bh_q, bh_d;
  logic          fresh_q, fresh_d;
  logic [FCW-1:0] fcnt_q, fcnt_d, fi_q, fi_d;
  logic [WCW-1:0] wcnt_q, wcnt_d, wi_q, wi_d, wj_q, wj_d;
  logic [CB-1:0] rw_q, rw_d, rh_q, rh_d;
  logic          found_q, found_d, drop_q, drop_d;
  logic [CB-1:0] bs_q, bs_d, bl_q, bl_d, bx_q, bx_d, by_q, by_d;
  box_t          cur_q, cur_d;
  logic [1:0]    piece_q, piece_d;
  status_e       stat_q, stat_d;
  logic          ovalid_q, ovalid_d;
  logic [OUT_W-1:0] odata_q, odata_d;

  logic          f_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [BW-1:0] f_wdata, f_rdata;
  logic          w_we;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [BW:0]   w_wdata, w_rdata;

  box_t          frd, wrd, placed, piece;
  logic          w_alive, ov, pen;
  logic [SW-1:0] fr, fb, pr, pb;
  logic [CB-1:0] lw, lh, s_v, l_v, cfg_v;
  logic          fits;

  mbp_ram #(.WIDTH(BW), .DEPTH(MAX_FREE)) u_free (
    .clk_i  (clk_i),
    .we_i   (f_we),
    .waddr_i(f_waddr),
    .wdata_i(f_wdata),
    .raddr_i(f_raddr),
    .rdata_o(f_rdata)
  );

  mbp_ram #(.WIDTH(BW + 1), .DEPTH(WORK_DEPTH)) u_work (
    .clk_i  (clk_i),
    .we_i   (w_we),
    .waddr_i(w_waddr),
    .wdata_i(w_wdata),
    .raddr_i(w_raddr),
    .rdata_o(w_rdata)
  );

  assign frd     = fresh_q ? box_t'{x: '0, y: '0, w: bw_q, h: bh_q} : box_t'(f_rdata);
  assign wrd     = box_t'(w_rdata[BW-1:0]);
  assign w_alive = w_rdata[BW];
  assign placed  = box_t'{x: bx_q, y: by_q, w: rw_q, h: rh_q};

  assign fr = ext(cur_q.x) + ext(cur_q.w);
  assign fb = ext(cur_q.y) + ext(cur_q.h);
  assign pr = ext(placed.x) + ext(placed.w);
  assign pb = ext(placed.y) + ext(placed.h);
  assign ov = (ext(cur_q.x) < pr) && (fr > ext(placed.x)) &&
              (ext(cur_q.y) < pb) && (fb > ext(placed.y));

  always_comb begin
    pen   = 1'b0;
    piece = cur_q;
    if (!ov) begin
      pen = (piece_q == 2'd0);
    end else begin
      unique case (piece_q)
        2'd0: begin
          pen   = placed.x > cur_q.x;
          piece = box_t'{x: cur_q.x, y: cur_q.y, w: placed.x - cur_q.x, h: cur_q.h};
        end
        2'd1: begin
          pen   = pr < fr;
          piece = box_t'{x: pr[CB-1:0], y: cur_q.y, w: CB'(fr - pr), h: cur_q.h};
        end
        2'd2: begin
          pen   = placed.y > cur_q.y;
          piece = box_t'{x: cur_q.x, y: cur_q.y, w: cur_q.w, h: placed.y - cur_q.y};
        end
        default: begin
          pen   = pb < fb;
          piece = box_t'{x: cur_q.x, y: pb[CB-1:0], w: cur_q.w, h: CB'(fb - pb)};
        end
      endcase
    end
  end

  assign fits = (frd.w >= rw_q) && (frd.h >= rh_q);
  assign lw   = frd.w - rw_q;
  assign lh   = frd.h - rh_q;
  assign s_v  = (lw < lh) ? lw : lh;
  assign l_v  = (lw < lh) ? lh : lw;
  assign cfg_v = (cfg_data_i > BIN_MAX) ? BIN_MAX : cfg_data_i;

  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  always_comb begin
    state_d  = state_q;
    bw_d     = bw_q;
    bh_d     = bh_q;
    fresh_d  = fresh_q;
    fcnt_d   = fcnt_q;
    fi_d     = fi_q;
    wcnt_d   = wcnt_q;
    wi_d     = wi_q;
    wj_d     = wj_q;
    rw_d     = rw_q;
    rh_d     = rh_q;
    found_d  = found_q;
    drop_d   = drop_q;
    bs_d     = bs_q;
    bl_d     = bl_q;
    bx_d     = bx_q;
    by_d     = by_q;
    cur_d    = cur_q;
    piece_d  = piece_q;
    stat_d   = stat_q;
    ovalid_d = ovalid_q;
    odata_d  = odata_q;
    f_we     = 1'b0;
    f_waddr  = fi_q[FAW-1:0];
    f_wdata  = w_rdata[BW-1:0];
    f_raddr  = fi_q[FAW-1:0];
    w_we     = 1'b0;
    w_waddr  = wcnt_q[WAW-1:0];
    w_wdata  = {1'b1, piece};
    w_raddr  = wj_q[WAW-1:0];

    if (ovalid_q && m_axis_tready) begin
      ovalid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (cfg_valid_i) begin
          if (cfg_index_i == REG_BIN_WIDTH || cfg_index_i == REG_BIN_HEIGHT) begin
            if (cfg_index_i == REG_BIN_WIDTH) begin
              bw_d = cfg_v;
            end else begin
              bh_d = cfg_v;
            end
            fresh_d = 1'b1;
            fcnt_d  = FCW'(1);
            wcnt_d  = '0;
          end
        end else if (s_axis_tvalid) begin
          rw_d    = s_axis_tdata[CB-1:0];
          rh_d    = s_axis_tdata[2*CB-1:CB];
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        if (rw_q == '0 || rh_q == '0 || rw_q > bw_q || rh_q > bh_q) begin
          stat_d  = STAT_REJECT;
          state_d = ST_FIN;
        end else begin
          fi_d    = '0;
          found_d = 1'b0;
          state_d = ST_SR_RD;
        end
      end
      ST_SR_RD: begin
        if (fi_q == fcnt_q) begin
          if (!found_q) begin
            stat_d  = STAT_NO_FIT;
            state_d = ST_FIN;
          end else begin
            fi_d    = '0;
            wcnt_d  = '0;
            drop_d  = 1'b0;
            state_d = ST_SP_RD;
          end
        end else begin
          state_d = ST_SR_EV;
        end
      end
      ST_SR_EV: begin
        if (fits && (!found_q || s_v < bs_q || (s_v == bs_q && l_v < bl_q))) begin
          found_d = 1'b1;
          bs_d    = s_v;
          bl_d    = l_v;
          bx_d    = frd.x;
          by_d    = frd.y;
        end
        fi_d    = fi_q + FCW'(1);
        state_d = ST_SR_RD;
      end
      ST_SP_RD: begin
        if (fi_q == fcnt_q) begin
          wi_d    = '0;
          state_d = ST_PR_RDI;
        end else begin
          state_d = ST_SP_GET;
        end
      end
      ST_SP_GET: begin
        cur_d   = frd;
        piece_d = 2'd0;
        state_d = ST_SP_PUSH;
      end
      ST_SP_PUSH: begin
        if (pen) begin
          if (wcnt_q >= WCW'(WORK_DEPTH)) begin
            drop_d = 1'b1;
          end else begin
            w_we   = 1'b1;
            wcnt_d = wcnt_q + WCW'(1);
          end
        end
        piece_d = piece_q + 2'd1;
        if (piece_q == 2'd3) begin
          fi_d    = fi_q + FCW'(1);
          state_d = ST_SP_RD;
        end
      end
      ST_PR_RDI: begin
        w_raddr = wi_q[WAW-1:0];
        if (wi_q == wcnt_q) begin
          fi_d    = '0;
          wj_d    = '0;
          fresh_d = 1'b0;
          state_d = ST_CP_RD;
        end else begin
          state_d = ST_PR_GETI;
        end
      end
      ST_PR_GETI: begin
        cur_d   = wrd;
        wj_d    = '0;
        state_d = ST_PR_RDJ;
      end
      ST_PR_RDJ: begin
        if (wj_q == wcnt_q) begin
          wi_d    = wi_q + WCW'(1);
          state_d = ST_PR_RDI;
        end else if (wj_q == wi_q) begin
          wj_d = wj_q + WCW'(1);
        end else begin
          state_d = ST_PR_CMP;
        end
      end
      ST_PR_CMP: begin
        if (w_alive && box_holds(wrd, cur_q)) begin
          w_we    = 1'b1;
          w_waddr = wi_q[WAW-1:0];
          w_wdata = {1'b0, cur_q};
          wi_d    = wi_q + WCW'(1);
          state_d = ST_PR_RDI;
        end else begin
          wj_d    = wj_q + WCW'(1);
          state_d = ST_PR_RDJ;
        end
      end
      ST_CP_RD: begin
        if (wj_q == wcnt_q) begin
          fcnt_d  = fi_q;
          stat_d  = STAT_PLACED;
          state_d = ST_FIN;
        end else begin
          state_d = ST_CP_WR;
        end
      end
      ST_CP_WR: begin
        if (w_alive) begin
          if (fi_q < FCW'(MAX_FREE)) begin
            f_we = 1'b1;
            fi_d = fi_q + FCW'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
        wj_d    = wj_q + WCW'(1);
        state_d = ST_CP_RD;
      end
      ST_FIN: begin
        if (!ovalid_q || m_axis_tready) begin
          ovalid_d = 1'b1;
          odata_d  = '0;
          odata_d[1:0] = stat_q;
          if (stat_q == STAT_PLACED) begin
            odata_d[PW+1:2]      = bx_q[PW-1:0];
            odata_d[2*PW+1:PW+2] = by_q[PW-1:0];
            odata_d[2*PW+2]      = drop_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      bw_q     <= BIN_MAX;
      bh_q     <= BIN_MAX;
      fresh_q  <= 1'b1;
      fcnt_q   <= FCW'(1);
      wcnt_q   <= '0;
      fi_q     <= '0;
      wi_q     <= '0;
      wj_q     <= '0;
      found_q  <= 1'b0;
      drop_q   <= 1'b0;
      piece_q  <= 2'd0;
      stat_q   <= STAT_PLACED;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      bw_q     <= bw_d;
      bh_q     <= bh_d;
      fresh_q  <= fresh_d;
      fcnt_q   <= fcnt_d;
      wcnt_q   <= wcnt_d;
      fi_q     <= fi_d;
      wi_q     <= wi_d;
      wj_q     <= wj_d;
      found_q  <= found_d;
      drop_q   <= drop_d;
      piece_q  <= piece_d;
      stat_q   <= stat_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q    <= rw_d;
    rh_q    <= rh_d;
    bs_q    <= bs_d;
    bl_q    <= bl_d;
    bx_q    <= bx_d;
    by_q    <= by_d;
    cur_q   <= cur_d;
    odata_q <= odata_d;
  end

  `MBP_ASSERT(a_work_bound, wcnt_q <= WCW'(WORK_DEPTH), "scratch count beyond depth")
  `MBP_ASSERT(a_free_bound, fcnt_q <= FCW'(MAX_FREE), "free count beyond capacity")
  `MBP_ASSERT(a_fresh_one, fresh_q |-> fcnt_q == FCW'(1), "restarted bin not single entry")
  `MBP_ASSERT(a_out_from_fin, $rose(m_axis_tvalid) |-> $past(state_q == ST_FIN), "result not from finish")

endmodule

@@ sim/maxrects_bssf_packer_tb.sv @@
// Self-checking testbench for maxrects_bssf_packer: directed and random rectangle requests.
// It keeps its own model of the free list and checks each result beat against it.
// Depends on mbp_pkg and the packer RTL.
module maxrects_bssf_packer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbp_pkg::*;

  localparam int unsigned NFREE = 64;
  localparam int unsigned NWORK = 256;
  localparam int unsigned BIN_LIMIT = 4096;
  localparam longint CYCLE_LIMIT = 100000000;

  typedef struct {
    int unsigned x, y, w, h;
  } rect_t;

  typedef struct {
    status_e     st;
    logic [11:0] px;
    logic [11:0] py;
    logic        ovf;
  } place_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [12:0] cfg_data_i = '0;

  int unsigned bin_w, bin_h;
  rect_t       free_rects[NFREE];
  int unsigned free_n;
  rect_t       scratch[NWORK];
  int unsigned scratch_n;
  bit          lost_piece;

  place_t      placements_due[$];
  int unsigned errors = 0;
  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint      cycles = 0;

  maxrects_bssf_packer dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic void restart_bin();
    free_rects[0] = '{0, 0, bin_w, bin_h};
    free_n = 1;
    scratch_n = 0;
  endfunction

  function automatic void scratch_add(int unsigned x, int unsigned y,
                                      int unsigned w, int unsigned h);
    if (scratch_n >= NWORK) begin
      lost_piece = 1'b1;
      return;
    end
    scratch[scratch_n] = '{x, y, w, h};
    scratch_n++;
  endfunction

  function automatic bit encloses(rect_t o, rect_t r);
    return r.x >= o.x && r.y >= o.y && r.x + r.w <= o.x + o.w && r.y + r.h <= o.y + o.h;
  endfunction

  function automatic place_t pack_rect(int unsigned w, int unsigned h);
    place_t      res;
    int          best;
    int unsigned best_s, best_l, lw, lh, s, l, i, j, k;
    rect_t       f, p;
    bit          gone;
    res = '{STAT_PLACED, 12'd0, 12'd0, 1'b0};
    if (w == 0 || h == 0 || w > bin_w || h > bin_h) begin
      res.st = STAT_REJECT;
      return res;
    end
    best = -1;
    best_s = '1;
    best_l = '1;
    for (i = 0; i < free_n; i++) begin
      f = free_rects[i];
      if (f.w >= w && f.h >= h) begin
        lw = f.w - w;
        lh = f.h - h;
        s = lw < lh ? lw : lh;
        l = lw < lh ? lh : lw;
        if (s < best_s || (s == best_s && l < best_l)) begin
          best = i;
          best_s = s;
          best_l = l;
        end
      end
    end
    if (best < 0) begin
      res.st = STAT_NO_FIT;
      return res;
    end
    p = '{free_rects[best].x, free_rects[best].y, w, h};
    lost_piece = 1'b0;
    scratch_n = 0;
    for (i = 0; i < free_n; i++) begin
      f = free_rects[i];
      if (f.x < p.x + p.w && f.x + f.w > p.x && f.y < p.y + p.h && f.y + f.h > p.y) begin
        if (p.x > f.x) scratch_add(f.x, f.y, p.x - f.x, f.h);
        if (p.x + p.w < f.x + f.w) scratch_add(p.x + p.w, f.y, f.x + f.w - p.x - p.w, f.h);
        if (p.y > f.y) scratch_add(f.x, f.y, f.w, p.y - f.y);
        if (p.y + p.h < f.y + f.h) scratch_add(f.x, p.y + p.h, f.w, f.y + f.h - p.y - p.h);
      end else begin
        scratch_add(f.x, f.y, f.w, f.h);
      end
    end
    i = 0;
    while (i < scratch_n) begin
      gone = 1'b0;
      for (j = 0; j < scratch_n && !gone; j++) begin
        if (j != i && encloses(scratch[j], scratch[i])) begin
          for (k = i; k + 1 < scratch_n; k++) scratch[k] = scratch[k + 1];
          scratch_n--;
          gone = 1'b1;
        end
      end
      if (!gone) i++;
    end
    if (scratch_n > NFREE) begin
      scratch_n = NFREE;
      lost_piece = 1'b1;
    end
    for (i = 0; i < scratch_n; i++) free_rects[i] = scratch[i];
    free_n = scratch_n;
    res.px = p.x[11:0];
    res.py = p.y[11:0];
    res.ovf = lost_piece;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    place_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (placements_due.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        want = placements_due.pop_front();
        if (m_axis_tdata[1:0] !== want.st) report_mismatch("status", m_axis_tdata[1:0], want.st);
        if (m_axis_tdata[13:2] !== want.px) report_mismatch("pos_x", m_axis_tdata[13:2], want.px);
        if (m_axis_tdata[25:14] !== want.py)
          report_mismatch("pos_y", m_axis_tdata[25:14], want.py);
        if (m_axis_tdata[26] !== want.ovf)
          report_mismatch("free_overflow", m_axis_tdata[26], want.ovf);
      end
    end
  end

  task automatic send_rect(int unsigned w, int unsigned h);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_gap_pct && gap < 40) gap++;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, h[12:0], w[12:0]};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    placements_due.insert(placements_due.size(), pack_rect(w, h));
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (placements_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, int unsigned value);
    int unsigned v;
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value[12:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    v = value & 13'h1fff;
    if (v > BIN_LIMIT) v = BIN_LIMIT;
    if (idx == REG_BIN_WIDTH) begin
      bin_w = v;
      restart_bin();
    end else if (idx == REG_BIN_HEIGHT) begin
      bin_h = v;
      restart_bin();
    end
  endtask

  task automatic set_bin(int unsigned w, int unsigned h);
    write_reg(REG_BIN_WIDTH, w);
    write_reg(REG_BIN_HEIGHT, h);
  endtask

  task automatic test_full_bin();
    send_rect(4096, 4096);
    send_rect(1, 1);
    set_bin(4096, 4096);
    send_rect(100, 50);
    send_rect(50, 100);
    send_rect(4000, 7);
  endtask

  task automatic test_size_reject();
    send_rect(0, 5);
    send_rect(5, 0);
    send_rect(0, 0);
    send_rect(4097, 1);
    send_rect(1, 8191);
    send_rect(8191, 8191);
  endtask

  task automatic test_config_extremes();
    set_bin(0, 0);
    send_rect(1, 1);
    set_bin(8191, 8191);
    send_rect(4096, 1);
    write_reg(reg_idx_e'(8'd2), 7);
    send_rect(4096, 1);
    set_bin(1, 1);
    send_rect(1, 1);
    send_rect(1, 1);
    set_bin(10, 3);
    send_rect(3, 3);
    send_rect(3, 3);
    send_rect(4, 2);
    send_rect(11, 1);
  endtask

  task automatic test_random(int unsigned gap_pct, int unsigned stall_pct, int unsigned n);
    int unsigned bw, bh, w, h, r;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 12 == 0) begin
        if ($urandom_range(3) == 0) begin
          bw = BIN_LIMIT;
          bh = BIN_LIMIT;
        end else begin
          bw = $urandom_range(128, 8);
          bh = $urandom_range(128, 8);
        end
        set_bin(bw, bh);
      end
      r = $urandom_range(9);
      if (r == 0) begin
        w = $urandom_range(8191);
        h = $urandom_range(8191);
      end else if (r == 1) begin
        w = $urandom_range(1) ? 0 : $urandom_range(bw);
        h = $urandom_range(1) ? 0 : bh + $urandom_range(8191 - bh);
      end else begin
        w = $urandom_range(bw / 3 + 1, 1);
        h = $urandom_range(bh / 3 + 1, 1);
      end
      send_rect(w, h);
    end
  endtask

  initial begin
    bin_w = BIN_LIMIT;
    bin_h = BIN_LIMIT;
    lost_piece = 1'b0;
    restart_bin();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_full_bin();
    test_size_reject();
    test_config_extremes();
    test_random(0, 0, 30);
    test_random(69, 0, 30);
    test_random(0, 69, 30);
    test_random(13, 13, 30);
    drain();
    repeat (200) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

@@ maxrects_bssf_packer.f @@
+incdir+rtl
rtl/mbp_pkg.sv
rtl/mbp_ram.sv
rtl/maxrects_bssf_packer.sv
sim/maxrects_bssf_packer_tb.sv
